FILE: rtl/core/fixed_point_vertex_rotate_scale_core_defines.svh
// Assertion macros for the vertex rotate and scale core.
// Expect clk_i and rst_ni in the scope of every use.
`ifndef FIXED_POINT_VERTEX_ROTATE_SCALE_CORE_DEFINES_SVH
`define FIXED_POINT_VERTEX_ROTATE_SCALE_CORE_DEFINES_SVH

`ifndef SYNTHESIS
`define FPVRS_ASSERT_NEXT(lbl, en, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (en) |=> (cons)) \
    else $error("fpvrs assertion failed");
`define FPVRS_ASSERT_DELAY(lbl, en, n, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (en) |-> ##n (cons)) \
    else $error("fpvrs assertion failed");
`else
`define FPVRS_ASSERT_NEXT(lbl, en, cons)
`define FPVRS_ASSERT_DELAY(lbl, en, n, cons)
`endif

`endif

FILE: rtl/core/fpvrs_pkg.sv
// Shared types and constants of the vertex rotate and scale core.
// No dependencies.
`default_nettype none

package fpvrs_pkg;

  localparam int COORD_BITS_DEF = 24;
  localparam int FRAC_BITS      = 10;
  localparam int GROW_SHIFT     = 15;
  localparam int ROT_COS        = 1023;
  localparam int ROT_SIN        = 41;

  localparam int PIX_BITS    = 10;
  localparam int SCREEN_BITS = 15;
  localparam int FLAG_BITS   = 6;
  localparam int CFG_IDX_BITS = 4;

  // rotation axis codes
  localparam int AXIS_X = 0;
  localparam int AXIS_Y = 1;
  localparam int AXIS_Z = 2;

  // register indexes
  localparam logic [CFG_IDX_BITS-1:0] REG_WIN_X_MIN = 4'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_WIN_X_MAX = 4'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_WIN_Y_MIN = 4'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_WIN_Y_MAX = 4'd3;

  localparam logic [PIX_BITS-1:0] WIN_X_MIN_RST = 10'd0;
  localparam logic [PIX_BITS-1:0] WIN_X_MAX_RST = 10'd639;
  localparam logic [PIX_BITS-1:0] WIN_Y_MIN_RST = 10'd75;
  localparam logic [PIX_BITS-1:0] WIN_Y_MAX_RST = 10'd434;

  // per-vertex attributes that ride along the pipeline
  typedef struct packed {
    logic [FLAG_BITS-1:0]  rot_flags;
    logic [PIX_BITS-1:0]   centre_x;
    logic [PIX_BITS-1:0]   centre_y;
    logic [GROW_SHIFT-1:0] grow_factor;
  } side_t;

endpackage

`default_nettype wire

FILE: rtl/core/fpvrs_rot_cell.sv
// One rotation cell: turns a coordinate pair by a fixed small angle when its flag is set.
// Depends on fpvrs_pkg.
`default_nettype none

module fpvrs_rot_cell #(
  parameter int COORD_BITS = fpvrs_pkg::COORD_BITS_DEF,
  parameter int AXIS       = fpvrs_pkg::AXIS_X,
  parameter bit NEG        = 1'b0,
  parameter int FLAG_BIT   = 0
) (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          valid_i,
  input  wire fpvrs_pkg::side_t        side_i,
  input  wire logic signed [COORD_BITS-1:0] x_i,
  input  wire logic signed [COORD_BITS-1:0] y_i,
  input  wire logic signed [COORD_BITS-1:0] z_i,
  output logic                         valid_o,
  output fpvrs_pkg::side_t             side_o,
  output logic signed [COORD_BITS-1:0] x_o,
  output logic signed [COORD_BITS-1:0] y_o,
  output logic signed [COORD_BITS-1:0] z_o
);

  localparam int EXT = 12;
  localparam int W   = COORD_BITS + EXT;
  localparam logic signed [W-1:0] COS_W = W'(fpvrs_pkg::ROT_COS);
  localparam logic signed [W-1:0] SIN_W =
    W'(NEG ? -fpvrs_pkg::ROT_SIN : fpvrs_pkg::ROT_SIN);

  logic signed [COORD_BITS-1:0] a, b, ra, rb;
  logic signed [COORD_BITS-1:0] x_d, y_d, z_d;
  logic signed [W-1:0] a_w, b_w, ta, tb, sa, sb;
  logic valid_q;
  fpvrs_pkg::side_t side_q;
  logic signed [COORD_BITS-1:0] x_q, y_q, z_q;

  always_comb begin
    case (AXIS)
      fpvrs_pkg::AXIS_Y: begin
        a = x_i;
        b = z_i;
      end
      fpvrs_pkg::AXIS_Z: begin
        a = x_i;
        b = y_i;
      end
      default: begin
        a = y_i;
        b = z_i;
      end
    endcase

    a_w = {{EXT{a[COORD_BITS-1]}}, a};
    b_w = {{EXT{b[COORD_BITS-1]}}, b};
    ta  = a_w * COS_W - b_w * SIN_W;
    tb  = a_w * SIN_W + b_w * COS_W;
    sa  = ta >>> fpvrs_pkg::FRAC_BITS;
    sb  = tb >>> fpvrs_pkg::FRAC_BITS;

    // clamp to the coordinate range when the upper bits are not all sign
    if ((&sa[W-1:COORD_BITS-1]) || !(|sa[W-1:COORD_BITS-1])) begin
      ra = sa[COORD_BITS-1:0];
    end else begin
      ra = sa[W-1] ? {1'b1, {(COORD_BITS-1){1'b0}}} : {1'b0, {(COORD_BITS-1){1'b1}}};
    end
    if ((&sb[W-1:COORD_BITS-1]) || !(|sb[W-1:COORD_BITS-1])) begin
      rb = sb[COORD_BITS-1:0];
    end else begin
      rb = sb[W-1] ? {1'b1, {(COORD_BITS-1){1'b0}}} : {1'b0, {(COORD_BITS-1){1'b1}}};
    end

    x_d = x_i;
    y_d = y_i;
    z_d = z_i;
    if (side_i.rot_flags[FLAG_BIT]) begin
      case (AXIS)
        fpvrs_pkg::AXIS_Y: begin
          x_d = ra;
          z_d = rb;
        end
        fpvrs_pkg::AXIS_Z: begin
          x_d = ra;
          y_d = rb;
        end
        default: begin
          y_d = ra;
          z_d = rb;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    side_q <= side_i;
    x_q    <= x_d;
    y_q    <= y_d;
    z_q    <= z_d;
  end

  assign valid_o = valid_q;
  assign side_o  = side_q;
  assign x_o     = x_q;
  assign y_o     = y_q;
  assign z_o     = z_q;

endmodule

`default_nettype wire

FILE: rtl/core/fpvrs_grow_cell.sv
// Growth cell: scales each coordinate by one plus the growth factor, saturated.
// Depends on fpvrs_pkg.
`default_nettype none

module fpvrs_grow_cell #(
  parameter int COORD_BITS = fpvrs_pkg::COORD_BITS_DEF
) (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          valid_i,
  input  wire fpvrs_pkg::side_t        side_i,
  input  wire logic signed [COORD_BITS-1:0] c_i [3],
  output logic                         valid_o,
  output fpvrs_pkg::side_t             side_o,
  output logic signed [COORD_BITS-1:0] c_o [3]
);

  localparam int EXT = fpvrs_pkg::GROW_SHIFT + 1;
  localparam int GW  = COORD_BITS + EXT;

  logic signed [GW-1:0] f_w;
  logic signed [GW-1:0] c_w [3];
  logic signed [GW-1:0] prod [3];
  logic signed [GW-1:0] sum [3];
  logic signed [COORD_BITS-1:0] c_d [3];
  logic valid_q;
  fpvrs_pkg::side_t side_q;
  logic signed [COORD_BITS-1:0] c_q [3];

  always_comb begin
    f_w = {{(GW-fpvrs_pkg::GROW_SHIFT){1'b0}}, side_i.grow_factor};
    for (int i = 0; i < 3; i++) begin
      c_w[i]  = {{EXT{c_i[i][COORD_BITS-1]}}, c_i[i]};
      prod[i] = c_w[i] * f_w;
      sum[i]  = c_w[i] + (prod[i] >>> fpvrs_pkg::GROW_SHIFT);
      if ((&sum[i][GW-1:COORD_BITS-1]) || !(|sum[i][GW-1:COORD_BITS-1])) begin
        c_d[i] = sum[i][COORD_BITS-1:0];
      end else begin
        c_d[i] = sum[i][GW-1] ? {1'b1, {(COORD_BITS-1){1'b0}}}
                              : {1'b0, {(COORD_BITS-1){1'b1}}};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    side_q <= side_i;
    c_q    <= c_d;
  end

  assign valid_o = valid_q;
  assign side_o  = side_q;
  assign c_o     = c_q;

endmodule

`default_nettype wire

FILE: rtl/core/fpvrs_screen_stage.sv
// Screen stage: rounds x and y to whole pixels and subtracts them from the centre.
// Depends on fpvrs_pkg.
`default_nettype none

module fpvrs_screen_stage #(
  parameter int COORD_BITS = fpvrs_pkg::COORD_BITS_DEF
) (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          valid_i,
  input  wire fpvrs_pkg::side_t        side_i,
  input  wire logic signed [COORD_BITS-1:0] c_i [3],
  output logic                         valid_o,
  output logic signed [COORD_BITS-1:0] c_o [3],
  output logic signed [fpvrs_pkg::SCREEN_BITS-1:0] sx_o,
  output logic signed [fpvrs_pkg::SCREEN_BITS-1:0] sy_o
);

  localparam int SB  = fpvrs_pkg::SCREEN_BITS;
  localparam int PXW = COORD_BITS - fpvrs_pkg::FRAC_BITS + 1;
  localparam int DW  = (COORD_BITS - 7 > 16) ? COORD_BITS - 7 : 16;

  logic signed [COORD_BITS-1:0] t [2];
  logic signed [COORD_BITS-1:0] px [2];
  logic signed [DW-1:0] px_w [2];
  logic signed [DW-1:0] cen_w [2];
  logic signed [DW-1:0] diff [2];
  logic signed [SB-1:0] s_d [2];
  logic valid_q;
  logic signed [COORD_BITS-1:0] c_q [3];
  logic signed [SB-1:0] sx_q, sy_q;

  always_comb begin
    cen_w[0] = {{(DW-fpvrs_pkg::PIX_BITS){1'b0}}, side_i.centre_x};
    cen_w[1] = {{(DW-fpvrs_pkg::PIX_BITS){1'b0}}, side_i.centre_y};
    for (int i = 0; i < 2; i++) begin
      // round half up: floor(v / 512) + 1, then halve
      t[i]    = (c_i[i] >>> (fpvrs_pkg::FRAC_BITS - 1)) + COORD_BITS'(1);
      px[i]   = t[i] >>> 1;
      px_w[i] = {{(DW-PXW){px[i][PXW-1]}}, px[i][PXW-1:0]};
      diff[i] = cen_w[i] - px_w[i];
      if ((&diff[i][DW-1:SB-1]) || !(|diff[i][DW-1:SB-1])) begin
        s_d[i] = diff[i][SB-1:0];
      end else begin
        s_d[i] = diff[i][DW-1] ? {1'b1, {(SB-1){1'b0}}} : {1'b0, {(SB-1){1'b1}}};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    c_q  <= c_i;
    sx_q <= s_d[0];
    sy_q <= s_d[1];
  end

  assign valid_o = valid_q;
  assign c_o     = c_q;
  assign sx_o    = sx_q;
  assign sy_o    = sy_q;

endmodule

`default_nettype wire

FILE: rtl/core/fixed_point_vertex_rotate_scale_core.sv
// Top level of the vertex rotate and scale core: rotation cell chain, growth,
// screen mapping, window test. Depends on fpvrs_pkg, the cells and the defines header.
//
// Fully pipelined: one vertex request is taken in every cycle (busy_o stays low) and
// its result appears on the result ports with valid_o high once it has passed the six
// rotation cells, one growth cell, one screen stage and the output register, in that
// order. The receiver cannot stall; valid_o is a one-cycle strobe per request.
// Window registers are written through the cfg port, which is always ready; write
// them only while no request is in flight. Writes to indexes past 3 are dropped.
`default_nettype none

`include "fixed_point_vertex_rotate_scale_core_defines.svh"

module fixed_point_vertex_rotate_scale_core #(
  parameter int COORD_BITS = fpvrs_pkg::COORD_BITS_DEF
) (
  input  wire                                     clk_i,
  input  wire                                     rst_ni,
  input  wire                                     start_i,
  output logic                                    busy_o,
  input  wire logic signed [COORD_BITS-1:0]       coord_x_i,
  input  wire logic signed [COORD_BITS-1:0]       coord_y_i,
  input  wire logic signed [COORD_BITS-1:0]       coord_z_i,
  input  wire [fpvrs_pkg::FLAG_BITS-1:0]          rot_flags_i,
  input  wire [fpvrs_pkg::PIX_BITS-1:0]           centre_x_i,
  input  wire [fpvrs_pkg::PIX_BITS-1:0]           centre_y_i,
  input  wire [fpvrs_pkg::GROW_SHIFT-1:0]         grow_factor_i,
  input  wire                                     cfg_valid_i,
  output logic                                    cfg_ready_o,
  input  wire [fpvrs_pkg::CFG_IDX_BITS-1:0]       cfg_index_i,
  input  wire [fpvrs_pkg::PIX_BITS-1:0]           cfg_data_i,
  output logic                                    valid_o,
  output logic signed [COORD_BITS-1:0]            new_x_o,
  output logic signed [COORD_BITS-1:0]            new_y_o,
  output logic signed [COORD_BITS-1:0]            new_z_o,
  output logic signed [fpvrs_pkg::SCREEN_BITS-1:0] screen_x_o,
  output logic signed [fpvrs_pkg::SCREEN_BITS-1:0] screen_y_o,
  output logic                                    out_of_window_o
);

  localparam int NCELL   = 6;
  localparam int LATENCY = NCELL + 3;
  localparam int SB      = fpvrs_pkg::SCREEN_BITS;

  logic [fpvrs_pkg::PIX_BITS-1:0] win_x_min_q, win_x_max_q, win_y_min_q, win_y_max_q;

  logic             valid_s [NCELL+1];
  fpvrs_pkg::side_t side_s  [NCELL+1];
  logic signed [COORD_BITS-1:0] x_s [NCELL+1];
  logic signed [COORD_BITS-1:0] y_s [NCELL+1];
  logic signed [COORD_BITS-1:0] z_s [NCELL+1];

  logic signed [COORD_BITS-1:0] grow_in [3];
  logic signed [COORD_BITS-1:0] grow_out [3];
  logic signed [COORD_BITS-1:0] scr_out [3];
  logic             grow_valid, scr_valid;
  fpvrs_pkg::side_t grow_side;
  logic signed [SB-1:0] sx, sy;
  logic signed [SB-1:0] xmin_w, xmax_w, ymin_w, ymax_w;
  logic             off_d;

  logic valid_q;
  logic signed [COORD_BITS-1:0] new_x_q, new_y_q, new_z_q;
  logic signed [SB-1:0] screen_x_q, screen_y_q;
  logic off_q;

  assign busy_o      = 1'b0;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_x_min_q <= fpvrs_pkg::WIN_X_MIN_RST;
      win_x_max_q <= fpvrs_pkg::WIN_X_MAX_RST;
      win_y_min_q <= fpvrs_pkg::WIN_Y_MIN_RST;
      win_y_max_q <= fpvrs_pkg::WIN_Y_MAX_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        fpvrs_pkg::REG_WIN_X_MIN: win_x_min_q <= cfg_data_i;
        fpvrs_pkg::REG_WIN_X_MAX: win_x_max_q <= cfg_data_i;
        fpvrs_pkg::REG_WIN_Y_MIN: win_y_min_q <= cfg_data_i;
        fpvrs_pkg::REG_WIN_Y_MAX: win_y_max_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign valid_s[0]             = start_i && !busy_o;
  assign side_s[0].rot_flags    = rot_flags_i;
  assign side_s[0].centre_x     = centre_x_i;
  assign side_s[0].centre_y     = centre_y_i;
  assign side_s[0].grow_factor  = grow_factor_i;
  assign x_s[0] = coord_x_i;
  assign y_s[0] = coord_y_i;
  assign z_s[0] = coord_z_i;

  // turn order: +X, +Y, +Z, then -X, -Y, -Z
  for (genvar i = 0; i < NCELL; i++) begin : g_cell
    fpvrs_rot_cell #(
      .COORD_BITS (COORD_BITS),
      .AXIS       (i % 3),
      .NEG        (i >= 3),
      .FLAG_BIT   (i)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (valid_s[i]),
      .side_i  (side_s[i]),
      .x_i     (x_s[i]),
      .y_i     (y_s[i]),
      .z_i     (z_s[i]),
      .valid_o (valid_s[i+1]),
      .side_o  (side_s[i+1]),
      .x_o     (x_s[i+1]),
      .y_o     (y_s[i+1]),
      .z_o     (z_s[i+1])
    );
  end

  assign grow_in[0] = x_s[NCELL];
  assign grow_in[1] = y_s[NCELL];
  assign grow_in[2] = z_s[NCELL];

  fpvrs_grow_cell #(
    .COORD_BITS (COORD_BITS)
  ) u_grow (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (valid_s[NCELL]),
    .side_i  (side_s[NCELL]),
    .c_i     (grow_in),
    .valid_o (grow_valid),
    .side_o  (grow_side),
    .c_o     (grow_out)
  );

  fpvrs_screen_stage #(
    .COORD_BITS (COORD_BITS)
  ) u_screen (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (grow_valid),
    .side_i  (grow_side),
    .c_i     (grow_out),
    .valid_o (scr_valid),
    .c_o     (scr_out),
    .sx_o    (sx),
    .sy_o    (sy)
  );

  // window bounds are unsigned; widen with a zero sign bit for a signed compare
  assign xmin_w = {{(SB-fpvrs_pkg::PIX_BITS){1'b0}}, win_x_min_q};
  assign xmax_w = {{(SB-fpvrs_pkg::PIX_BITS){1'b0}}, win_x_max_q};
  assign ymin_w = {{(SB-fpvrs_pkg::PIX_BITS){1'b0}}, win_y_min_q};
  assign ymax_w = {{(SB-fpvrs_pkg::PIX_BITS){1'b0}}, win_y_max_q};
  assign off_d  = (sx < xmin_w) || (sx > xmax_w) || (sy < ymin_w) || (sy > ymax_w);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= scr_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    new_x_q    <= scr_out[0];
    new_y_q    <= scr_out[1];
    new_z_q    <= scr_out[2];
    screen_x_q <= sx;
    screen_y_q <= sy;
    off_q      <= off_d;
  end

  assign valid_o         = valid_q;
  assign new_x_o         = new_x_q;
  assign new_y_o         = new_y_q;
  assign new_z_o         = new_z_q;
  assign screen_x_o      = screen_x_q;
  assign screen_y_o      = screen_y_q;
  assign out_of_window_o = off_q;

  `FPVRS_ASSERT_DELAY(a_latency, start_i && !busy_o, LATENCY, valid_o)
  `FPVRS_ASSERT_DELAY(a_no_turn_passes, valid_s[0] && (rot_flags_i == '0), NCELL,
    (x_s[NCELL] == $past(x_s[0], NCELL)) && (y_s[NCELL] == $past(y_s[0], NCELL))
    && (z_s[NCELL] == $past(z_s[0], NCELL)))
  `FPVRS_ASSERT_NEXT(a_zero_grow_holds,
    valid_s[NCELL] && (side_s[NCELL].grow_factor == '0),
    (grow_out[0] == $past(x_s[NCELL])) && (grow_out[2] == $past(z_s[NCELL])))

endmodule

`default_nettype wire
